@@ rtl/core/rsm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsm_pkg - shared types and constants of the 3/4 polyphase resampler
// Payload structs, controller/datapath command and status, fixed constants.
// ----------------------------------------------------------------------------
package rsm_pkg;

    localparam int UP_FACTOR      = 3;
    localparam int DOWN_FACTOR    = 4;
    localparam int FILTER_LEN_DEF = 552;
    localparam int SAMPLE_WIDTH   = 16;
    localparam int FRAC_BITS      = SAMPLE_WIDTH - 1;
    localparam int COEF_IDX_W     = 10;
    localparam int PHASE_W        = 2;
    // delay of branch 0 for output phase 0
    localparam int DELAY_BASE     = 2;

    localparam logic KIND_COEF   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic                           kind;
        logic [COEF_IDX_W-1:0]          coef_index;
        logic signed [SAMPLE_WIDTH-1:0] value;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_out;
        logic [PHASE_W-1:0]             out_phase;
        logic                           last;
    } t_out;

    typedef struct packed {
        logic               load_coef;
        logic               push_sample;
        logic               setup;
        logic               issue;
        logic               emit;
        logic [PHASE_W-1:0] phase;
    } t_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_stat;

endpackage

@@ rtl/core/rsm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsm_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/rsm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsm_ctrl - sequencer of the resampler
// Input handshake, sample phase count and the MAC schedule for each output.
// ----------------------------------------------------------------------------
module rsm_ctrl #(
    parameter int FILTER_LEN = rsm_pkg::FILTER_LEN_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_kind,
    output logic          o_in_ready,
    output rsm_pkg::t_cmd o_cmd,
    input  rsm_pkg::t_stat i_stat
);
    import rsm_pkg::*;

    localparam int NPH  = UP_FACTOR * DOWN_FACTOR;
    localparam int TAPS = FILTER_LEN / NPH;
    localparam int NMAC = DOWN_FACTOR * TAPS;
    localparam int K_W  = $clog2(NMAC);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SETUP = 5'b00010,
        S_MAC   = 5'b00100,
        S_FLUSH = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [PHASE_W-1:0] r_in_phase, n_in_phase;
    logic [PHASE_W-1:0] r_r, n_r;
    logic [K_W-1:0]     r_k, n_k;
    logic               w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid & o_in_ready;

    always_comb begin
        n_state    = r_state;
        n_in_phase = r_in_phase;
        n_r        = r_r;
        n_k        = r_k;
        o_cmd      = '0;
        o_cmd.phase = r_r;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_kind == KIND_COEF) begin
                        o_cmd.load_coef = 1'b1;
                    end else begin
                        o_cmd.push_sample = 1'b1;
                        n_in_phase = (r_in_phase == PHASE_W'(DOWN_FACTOR - 1)) ?
                                     '0 : r_in_phase + 1'b1;
                        if (r_in_phase == '0) begin
                            n_r     = '0;
                            n_state = S_SETUP;
                        end
                    end
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_k         = '0;
                n_state     = S_MAC;
            end
            S_MAC: begin
                o_cmd.issue = 1'b1;
                n_k         = r_k + 1'b1;
                if (r_k == K_W'(NMAC - 1)) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!i_stat.pipe_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_r == PHASE_W'(UP_FACTOR - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_r     = r_r + 1'b1;
                        n_state = S_SETUP;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_phase <= '0;
            r_r        <= '0;
            r_k        <= '0;
        end else begin
            r_state    <= n_state;
            r_in_phase <= n_in_phase;
            r_r        <= n_r;
            r_k        <= n_k;
        end
    end

endmodule

@@ rtl/core/rsm_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsm_dp - datapath of the resampler
// Coefficient and history RAMs, address generators, MAC pipeline, output reg.
// ----------------------------------------------------------------------------
module rsm_dp #(
    parameter int FILTER_LEN = rsm_pkg::FILTER_LEN_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rsm_pkg::t_in   i_in_data,
    input  rsm_pkg::t_cmd  i_cmd,
    output rsm_pkg::t_stat o_stat,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rsm_pkg::t_out  o_out_data
);
    import rsm_pkg::*;

    localparam int NPH      = UP_FACTOR * DOWN_FACTOR;
    localparam int TAPS     = FILTER_LEN / NPH;
    localparam int HIST_LEN = DOWN_FACTOR * TAPS + DELAY_BASE;
    localparam int CA_W     = $clog2(FILTER_LEN);
    localparam int HA_W     = $clog2(HIST_LEN);
    localparam int HC_W     = $clog2(HIST_LEN + 1);
    localparam int PROD_W   = 2 * SAMPLE_WIDTH;
    localparam int ACC_W    = PROD_W + $clog2(FILTER_LEN) + 1;

    localparam logic signed [ACC_W-1:0] RND   = ACC_W'(2 ** (FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'(2 ** FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] Q_MIN = -Q_MAX - ACC_W'(1);

    logic [HA_W-1:0]           r_wp;
    logic [HC_W-1:0]           r_count;
    logic [CA_W-1:0]           r_ca;
    logic [HA_W-1:0]           r_ha;
    logic [HC_W-1:0]           r_hi;
    logic                      r_v1, r_m1, r_v2;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    t_out                      r_out;
    logic                      r_out_valid;

    logic [HA_W-1:0]           w_wp_inc;
    logic [HA_W:0]             w_ha_sum;
    logic [HA_W-1:0]           w_ha_start;
    logic                      w_coef_we;
    logic [SAMPLE_WIDTH-1:0]   w_coef_q, w_hist_q;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [ACC_W-1:0]   w_t, w_q;
    logic signed [SAMPLE_WIDTH-1:0] w_sat;

    assign w_wp_inc = (r_wp == HA_W'(HIST_LEN - 1)) ? '0 : r_wp + 1'b1;
    assign w_coef_we = i_cmd.load_coef &
                       (32'(i_in_data.coef_index) < 32'(FILTER_LEN));

    // start of the history walk: newest slot minus (DELAY_BASE - phase), wrapped
    assign w_ha_sum = (HA_W+1)'(r_wp) + (HA_W+1)'(HIST_LEN - DELAY_BASE) +
                      (HA_W+1)'(i_cmd.phase);
    assign w_ha_start = (w_ha_sum >= (HA_W+1)'(HIST_LEN)) ?
                        HA_W'(w_ha_sum - (HA_W+1)'(HIST_LEN)) : HA_W'(w_ha_sum);

    rsm_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (FILTER_LEN)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (CA_W'(i_in_data.coef_index)),
        .i_wdata (i_in_data.value),
        .i_re    (i_cmd.issue),
        .i_raddr (r_ca),
        .o_rdata (w_coef_q)
    );

    rsm_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (HIST_LEN)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push_sample),
        .i_waddr (w_wp_inc),
        .i_wdata (i_in_data.value),
        .i_re    (i_cmd.issue),
        .i_raddr (r_ha),
        .o_rdata (w_hist_q)
    );

    // signed 16 x 16 product, full width
    assign w_prod = $signed(w_coef_q) * $signed(w_hist_q);

    // round half up, floor shift, saturate
    assign w_t = r_acc + RND;
    assign w_q = w_t >>> FRAC_BITS;
    always_comb begin
        priority if (w_q > Q_MAX) begin
            w_sat = SAMPLE_WIDTH'(Q_MAX);
        end else if (w_q < Q_MIN) begin
            w_sat = SAMPLE_WIDTH'(Q_MIN);
        end else begin
            w_sat = SAMPLE_WIDTH'(w_q);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_count     <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.push_sample) begin
                r_wp <= w_wp_inc;
                if (r_count != HC_W'(HIST_LEN)) begin
                    r_count <= r_count + 1'b1;
                end
            end
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // address generators and MAC pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_ca  <= CA_W'(i_cmd.phase);
            r_hi  <= HC_W'(DELAY_BASE) - HC_W'(i_cmd.phase);
            r_ha  <= w_ha_start;
            r_acc <= '0;
        end else begin
            if (i_cmd.issue) begin
                r_ca <= r_ca + CA_W'(UP_FACTOR);
                r_hi <= r_hi + 1'b1;
                r_ha <= (r_ha == '0) ? HA_W'(HIST_LEN - 1) : r_ha - 1'b1;
                r_m1 <= (r_hi < r_count);
            end
            if (r_v2) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
        if (r_v1) begin
            // history slots not yet written read as zero
            r_prod <= r_m1 ? w_prod : '0;
        end
        if (i_cmd.emit) begin
            r_out.sample_out <= w_sat;
            r_out.out_phase  <= i_cmd.phase;
            r_out.last       <= (i_cmd.phase == PHASE_W'(UP_FACTOR - 1));
        end
    end

    assign o_stat.pipe_busy = r_v1 | r_v2;
    assign o_stat.out_free  = !r_out_valid | i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out;

endmodule

@@ rtl/core/polyphase_resampler_3_over_4.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphase_resampler_3_over_4 - 3/4 rational resampler, polyphase FIR
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data): one transaction is
//   either a coefficient load (kind 0, coef_index, value) or a Q1.15 sample
//   (kind 1). Loads with coef_index >= FILTER_LEN are dropped.
//   Output channel (o_out_valid / i_out_ready / o_out_data): three Q1.15
//   results per group, out_phase 0..2, last set on the third.
//   A group starts on the first sample after reset and every fourth after.
//   Sequencing: a load or a non-group sample leaves the block idle. A group
//   start sample occupies the block for three output passes, each made of
//   one setup step, 4*TAPS MACs on the single shared multiplier (the rate
//   limit), a pipeline flush and one write into the output register. No
//   input is taken until the third result enters the output register.
//   Reset clears the sample history (via a fill count), the sample phase
//   counter and all handshake state; coefficients must be reloaded.
//   A stalled receiver holds the single output register; the next MAC pass
//   runs meanwhile and waits only when its own result is ready. After the
//   last result of a group enters the output register, new input is
//   accepted even while that result is still waiting.
// ----------------------------------------------------------------------------
module polyphase_resampler_3_over_4 #(
    parameter int FILTER_LEN = rsm_pkg::FILTER_LEN_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rsm_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output rsm_pkg::t_out o_out_data
);
    import rsm_pkg::*;

    // controller -> datapath commands, datapath -> controller status
    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer: handshake, phase count, MAC schedule
    rsm_ctrl #(
        .FILTER_LEN (FILTER_LEN)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_kind  (i_in_data.kind),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    // RAMs, address generation, MAC, rounding and output register
    rsm_dp #(
        .FILTER_LEN (FILTER_LEN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    // a transaction is only taken once the MAC pipeline has drained
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> !w_stat.pipe_busy)
        else $error("input taken while MAC pipeline busy");

    // a result never overwrites one still waiting
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!o_out_valid || i_out_ready))
        else $error("output register overwritten");

    // after the third result of a group the block takes input again
    a_group_end_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit && w_cmd.phase == PHASE_W'(UP_FACTOR - 1)) |=> o_in_ready)
        else $error("not ready after group end");
`endif

endmodule

@@ verif/polyphase_resampler_3_over_4_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphase_resampler_3_over_4_tb - self-checking bench of the 3/4 resampler
// Loads the 552-tap prototype, drives full-scale and random sample streams
// with bursty input and a stalling receiver, and checks every output
// transaction against a cycle-free polyphase FIR predictor kept in the bench.
// ----------------------------------------------------------------------------
module polyphase_resampler_3_over_4_tb;

    import rsm_pkg::*;

    localparam int FILTER_LEN = FILTER_LEN_DEF;
    localparam int NPHASES    = UP_FACTOR * DOWN_FACTOR;
    localparam int TAPS       = FILTER_LEN / NPHASES;
    localparam int HIST_LEN   = DOWN_FACTOR * TAPS + 2;
    localparam int IDLE_LIMIT = 20000;   // cycles with no transaction at all
    localparam int TAIL_WAIT  = 600;     // a bit more than one group pass
    localparam int RANDOM_ITEMS = 230;

    localparam longint SAT_MAX = (64'sd1 <<< FRAC_BITS) - 1;
    localparam longint SAT_MIN = -(64'sd1 <<< FRAC_BITS);

    // DUT inputs start at known values
    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_ready = 1'b0;
    t_in  i_in_data   = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    // predictor state
    logic signed [SAMPLE_WIDTH-1:0] coef_mem [FILTER_LEN];
    logic signed [SAMPLE_WIDTH-1:0] hist_line [HIST_LEN];
    logic [PHASE_W-1:0]             sample_count;
    t_out                           resampled_q[$];   // outputs still to come

    int fail_count  = 0;
    int idle_cycles = 0;
    int burst_left  = 0;     // sender: transactions left in current burst
    int ready_run   = 0;     // receiver: cycles left at current ready level
    logic ready_level = 1'b0;
    t_out want_out;

    polyphase_resampler_3_over_4 i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor: update on each accepted input transaction. A load only
    // touches the coefficient store (out-of-range index dropped); a sample
    // shifts the history, and on a group start yields three outputs.
    // Output r sums branches b: phase r+3b, tap j, history (b+2-r)+4j.
    // ------------------------------------------------------------------
    function automatic void resample_predict(input t_in item);
        longint acc;
        int     r;
        int     b;
        int     j;
        int     hi;
        int     ci;
        t_out   res;
        if (item.kind == KIND_COEF) begin
            if (item.coef_index < FILTER_LEN)
                coef_mem[item.coef_index] = item.value;
            return;
        end
        for (int i = HIST_LEN - 1; i > 0; i--)
            hist_line[i] = hist_line[i-1];
        hist_line[0] = item.value;
        if (sample_count != 0) begin
            sample_count = PHASE_W'((sample_count + 1) % DOWN_FACTOR);
            return;
        end
        sample_count = PHASE_W'(1);
        for (r = 0; r < UP_FACTOR; r++) begin
            acc = 0;
            for (b = 0; b < DOWN_FACTOR; b++) begin
                for (j = 0; j < TAPS; j++) begin
                    hi = b + DELAY_BASE - r + DOWN_FACTOR * j;
                    ci = r + UP_FACTOR * b + NPHASES * j;
                    if (hi >= 0 && hi < HIST_LEN && ci < FILTER_LEN)
                        acc += longint'(hist_line[hi]) * longint'(coef_mem[ci]);
                end
            end
            // round half up, floor shift, then clamp to Q1.15
            acc = (acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            if (acc > SAT_MAX) acc = SAT_MAX;
            if (acc < SAT_MIN) acc = SAT_MIN;
            res.sample_out = acc[SAMPLE_WIDTH-1:0];
            res.out_phase  = r[PHASE_W-1:0];
            res.last       = (r == UP_FACTOR - 1);
            resampled_q.push_back(res);
        end
    endfunction

    task automatic report_mismatch(input string why, input t_out got, input t_out want);
        $display("[%0t] MISMATCH %s: got out=%0d ph=%0d last=%0b, want out=%0d ph=%0d last=%0b",
                 $realtime, why, got.sample_out, got.out_phase, got.last,
                 want.sample_out, want.out_phase, want.last);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // Sender: one transaction per call. Bursts of random length, random
    // gaps between them (mostly short, sometimes zero, rarely longer than
    // a whole group pass). Always entered and left just after a rising edge.
    // Valid is left high after acceptance; the next call either replaces
    // the payload in the same step or drops valid for a gap.
    // ------------------------------------------------------------------
    task automatic send_item(input t_in item);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                9:       gap = $urandom_range(20, 700);
                default: gap = $urandom_range(1, 5);
            endcase
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        resample_predict(item);
        burst_left--;
    endtask

    task automatic send_coef(input int idx, input int val);
        t_in item;
        item.kind       = KIND_COEF;
        item.coef_index = idx[COEF_IDX_W-1:0];
        item.value      = val[SAMPLE_WIDTH-1:0];
        send_item(item);
    endtask

    task automatic send_sample(input int val);
        t_in item;
        item.kind       = KIND_SAMPLE;
        item.coef_index = $urandom_range(0, 1023);   // don't care for samples
        item.value      = val[SAMPLE_WIDTH-1:0];
        send_item(item);
    endtask

    // Sender holds off until every predicted output has been taken.
    task automatic wait_for_outputs();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (resampled_q.size() != 0);
    endtask

    function automatic int rand_sample();
        case ($urandom_range(0, 9))
            0:       return 32767;
            1:       return -32768;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------

    // All taps at positive full scale, plus loads past the end (dropped).
    task automatic test_full_scale_coefs();
        for (int k = 0; k < FILTER_LEN; k++)
            send_coef(k, 32767);
        send_coef(FILTER_LEN, -32768);
        send_coef(1023, -32768);
    endtask

    // Group starts from zero history, then full-scale runs of both signs
    // drive the accumulator into positive and negative saturation.
    task automatic test_saturation();
        send_sample(32767);
        send_sample(0);
        send_sample(-1);
        send_sample(1);
        repeat (8) send_sample(32767);
        repeat (8) send_sample(-32768);
    endtask

    // Realistic prototype: small random taps, extremes at both ends.
    task automatic test_random_coefs();
        send_coef(0, -32768);
        for (int k = 1; k < FILTER_LEN - 1; k++)
            send_coef(k, int'($urandom_range(0, 4095)) - 2048);
        send_coef(FILTER_LEN - 1, 32767);
    endtask

    // Pressure: one group start, then no input until its outputs are out.
    task automatic test_drain_pause();
        send_sample(rand_sample());
        wait_for_outputs();
        repeat (3) send_sample(rand_sample());
    endtask

    // Mostly samples; occasional tap rewrites and out-of-range loads.
    task automatic test_random_traffic();
        int sel;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sel = $urandom_range(0, 19);
            if (sel == 0)
                send_coef($urandom_range(FILTER_LEN, 1023), int'($signed(16'($urandom))));
            else if (sel <= 2)
                send_coef($urandom_range(0, FILTER_LEN - 1),
                          int'($urandom_range(0, 4095)) - 2048);
            else if (sel == 3)
                send_coef($urandom_range(0, FILTER_LEN - 1), int'($signed(16'($urandom))));
            else
                send_sample(rand_sample());
            if (n == 90 || n == 170)
                wait_for_outputs();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        for (int i = 0; i < HIST_LEN; i++)
            hist_line[i] = '0;
        for (int k = 0; k < FILTER_LEN; k++)
            coef_mem[k] = '0;
        sample_count = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_full_scale_coefs();
        test_saturation();
        test_random_coefs();
        test_drain_pause();
        test_random_traffic();

        wait_for_outputs();
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Receiver: alternating runs of ready high / low, with occasional long
    // stalls and long stall-free stretches.
    always @(posedge i_clk) begin
        if (ready_run == 0) begin
            ready_level = ~ready_level;
            if (ready_level)
                ready_run = ($urandom_range(0, 4) == 0) ? $urandom_range(200, 800)
                                                        : $urandom_range(1, 40);
            else
                ready_run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                                        : $urandom_range(1, 6);
        end
        i_out_ready <= ready_level;
        ready_run--;
    end

    // Output checker: each accepted transaction against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (resampled_q.size() == 0) begin
                report_mismatch("output with nothing expected", o_out_data, '0);
            end else begin
                want_out = resampled_q.pop_front();
                if (o_out_data.sample_out !== want_out.sample_out ||
                    o_out_data.out_phase  !== want_out.out_phase  ||
                    o_out_data.last       !== want_out.last)
                    report_mismatch("field", o_out_data, want_out);
            end
        end
    end

    // Watchdog: too long without any transaction on either channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
